// ===== hdl/tprx_pkg.sv =====
package tprx_pkg;

   localparam int MAX_PACKET = 82;
   localparam int CNT_W = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [3:0] KIND_TELEMETRY = 4'hA;
   localparam logic [3:0] KIND_SCIENTIFIC = 4'h1;
   localparam logic [CNT_W-1:0] MIN_TELEMETRY = CNT_W'(16);
   localparam logic [CNT_W-1:0] MIN_SCIENTIFIC = CNT_W'(47);
   localparam logic [CNT_W-1:0] CRC_SPAN = CNT_W'(15);
   localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PACKET);

   localparam logic [2:0] STATUS_TEL_OK = 3'd0;
   localparam logic [2:0] STATUS_SCI_OK = 3'd1;
   localparam logic [2:0] STATUS_BAD_TYPE = 3'd2;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd3;
   localparam logic [2:0] STATUS_BAD_TEAM = 3'd4;
   localparam logic [2:0] STATUS_BAD_CRC = 3'd5;

   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic             keep;
      logic [CNT_W-1:0] idx;
   } word_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hdl/tprx_front.sv =====
module tprx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_last_byte,
   input  logic                q_full,
   output logic                q_push,
   output tprx_pkg::word_type  q_word
);

   logic [tprx_pkg::CNT_W-1:0] cnt_ff;
   logic [tprx_pkg::CNT_W-1:0] cnt_in;
   logic                       keep;

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;
   assign keep = cnt_ff < tprx_pkg::MAX_LEN;

   always_comb begin
      q_word.data = req_rx_byte;
      q_word.last = req_last_byte;
      q_word.keep = keep;
      q_word.idx = cnt_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (q_push) begin
         if (req_last_byte) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + tprx_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/tprx_queue.sv =====
module tprx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tprx_pkg::word_type  push_word,
   output logic                full,
   input  logic                pop,
   output tprx_pkg::word_type  pop_word,
   output logic                empty
);

   tprx_pkg::word_type              mem [tprx_pkg::QUEUE_DEPTH];
   logic [tprx_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tprx_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tprx_pkg::QPTR_W:0]       fill_ff, fill_in;

   assign full = fill_ff == (tprx_pkg::QPTR_W+1)'(tprx_pkg::QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign pop_word = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tprx_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + tprx_pkg::QPTR_W'(1) : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (tprx_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (tprx_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== hdl/tprx_back.sv =====
module tprx_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [3:0]                 team_id,
   input  tprx_pkg::word_type         q_word,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic signed [23:0]         rsp_latitude,
   output logic signed [23:0]         rsp_longitude,
   output logic signed [15:0]         rsp_vertical_velocity,
   output logic [15:0]                rsp_altitude,
   output logic [31:0]                rsp_timestamp,
   output logic [7:0]                 rsp_flag_bitmap,
   output logic [tprx_pkg::CNT_W-1:0] rsp_packet_length
);

   logic [tprx_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  crc15_ff, crc15_in;
   logic [7:0]  crc_prev_ff, crc_prev_in;
   logic [7:0]  final_ff, final_in;
   logic [7:0]  byte16_ff, byte16_in;
   logic [7:0]  type_ff, type_in;
   logic [23:0] lat_ff, lat_in;
   logic [23:0] lon_ff, lon_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  bitmap_ff, bitmap_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 status_ff;
   logic signed [23:0]         lat_out_ff;
   logic signed [23:0]         lon_out_ff;
   logic signed [15:0]         speed_out_ff;
   logic [15:0]                height_out_ff;
   logic [31:0]                time_out_ff;
   logic [7:0]                 bitmap_out_ff;
   logic [tprx_pkg::CNT_W-1:0] len_out_ff;

   logic                       out_free;
   logic                       finish;
   logic [tprx_pkg::CNT_W-1:0] i;
   logic [7:0]                 b;
   logic                       take;
   logic                       sci_now;
   logic                       tel;
   logic                       sci;
   logic [2:0]                 status;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop = !q_empty && (!q_word.last || out_free);
   assign finish = q_pop && q_word.last;
   assign i = q_word.idx;
   assign b = q_word.data;
   assign take = q_word.keep;
   assign sci_now = type_ff[7:4] == tprx_pkg::KIND_SCIENTIFIC;

   always_comb begin
      cnt_in = cnt_ff;
      crc_in = crc_ff;
      crc15_in = crc15_ff;
      crc_prev_in = crc_prev_ff;
      final_in = final_ff;
      byte16_in = byte16_ff;
      type_in = type_ff;
      lat_in = lat_ff;
      lon_in = lon_ff;
      speed_in = speed_ff;
      height_in = height_ff;
      time_in = time_ff;
      bitmap_in = bitmap_ff;
      if (take) begin
         if (i == tprx_pkg::CNT_W'(0)) type_in = b;
         if (i >= tprx_pkg::CNT_W'(1) && i <= tprx_pkg::CNT_W'(3)) lat_in = {lat_ff[15:0], b};
         if (i >= tprx_pkg::CNT_W'(4) && i <= tprx_pkg::CNT_W'(6)) lon_in = {lon_ff[15:0], b};
         if (i >= tprx_pkg::CNT_W'(7) && i <= tprx_pkg::CNT_W'(8)) speed_in = {speed_ff[7:0], b};
         if (i >= tprx_pkg::CNT_W'(9) && i <= tprx_pkg::CNT_W'(10)) begin
            height_in = {height_ff[7:0], b};
         end
         if (i == tprx_pkg::CNT_W'(5)) bitmap_in = b;
         if (i == tprx_pkg::CNT_W'(15)) byte16_in = b;
         if ((sci_now && i >= tprx_pkg::CNT_W'(1) && i <= tprx_pkg::CNT_W'(4))
             || (!sci_now && i >= tprx_pkg::CNT_W'(11) && i <= tprx_pkg::CNT_W'(14))) begin
            time_in = {time_ff[23:0], b};
         end
         crc_prev_in = crc_ff;
         crc_in = tprx_pkg::crc8_step(crc_ff, b);
         final_in = b;
         cnt_in = i + tprx_pkg::CNT_W'(1);
         if (cnt_in == tprx_pkg::CRC_SPAN) crc15_in = crc_in;
      end
   end

   always_comb begin
      tel = type_in[7:4] == tprx_pkg::KIND_TELEMETRY;
      sci = type_in[7:4] == tprx_pkg::KIND_SCIENTIFIC;
      if (!tel && !sci) begin
         status = tprx_pkg::STATUS_BAD_TYPE;
      end else if (cnt_in < (tel ? tprx_pkg::MIN_TELEMETRY : tprx_pkg::MIN_SCIENTIFIC)) begin
         status = tprx_pkg::STATUS_TOO_SHORT;
      end else if (type_in[3:0] != team_id) begin
         status = tprx_pkg::STATUS_BAD_TEAM;
      end else if (tel ? (crc15_in != byte16_in) : (crc_prev_in != final_in)) begin
         status = tprx_pkg::STATUS_BAD_CRC;
      end else begin
         status = tel ? tprx_pkg::STATUS_TEL_OK : tprx_pkg::STATUS_SCI_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // clear per-packet state after the last word
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         cnt_ff <= '0;
         crc_ff <= '0;
         crc15_ff <= '0;
         crc_prev_ff <= '0;
         final_ff <= '0;
         byte16_ff <= '0;
         type_ff <= '0;
         lat_ff <= '0;
         lon_ff <= '0;
         speed_ff <= '0;
         height_ff <= '0;
         time_ff <= '0;
         bitmap_ff <= '0;
      end else if (q_pop) begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
         crc15_ff <= crc15_in;
         crc_prev_ff <= crc_prev_in;
         final_ff <= final_in;
         byte16_ff <= byte16_in;
         type_ff <= type_in;
         lat_ff <= lat_in;
         lon_ff <= lon_in;
         speed_ff <= speed_in;
         height_ff <= height_in;
         time_ff <= time_in;
         bitmap_ff <= bitmap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= status;
         len_out_ff <= cnt_in;
         lat_out_ff <= '0;
         lon_out_ff <= '0;
         speed_out_ff <= '0;
         height_out_ff <= '0;
         time_out_ff <= '0;
         bitmap_out_ff <= '0;
         if (status == tprx_pkg::STATUS_TEL_OK) begin
            lat_out_ff <= lat_in;
            lon_out_ff <= lon_in;
            speed_out_ff <= speed_in;
            height_out_ff <= height_in;
            time_out_ff <= time_in;
         end else if (status == tprx_pkg::STATUS_SCI_OK) begin
            time_out_ff <= time_in;
            bitmap_out_ff <= bitmap_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_latitude = lat_out_ff;
   assign rsp_longitude = lon_out_ff;
   assign rsp_vertical_velocity = speed_out_ff;
   assign rsp_altitude = height_out_ff;
   assign rsp_timestamp = time_out_ff;
   assign rsp_flag_bitmap = bitmap_out_ff;
   assign rsp_packet_length = len_out_ff;

endmodule

// ===== hdl/telemetry_packet_receiver_unit.sv =====
// Packet receiver for CRC-8 (poly 0x07) framed radio packets: takes one byte
// per cycle while the queue is not full, with a last-byte flag, and returns
// one result word per packet, registered via the queue and then the output
// register. A four-word queue sits between the input-side byte counter and
// the CRC and field-capture unit, so a stalled result only stops input once
// that queue fills. Set the team number while no packet is in flight.
module telemetry_packet_receiver_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [3:0]                 csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic signed [23:0]         rsp_latitude,
   output logic signed [23:0]         rsp_longitude,
   output logic signed [15:0]         rsp_vertical_velocity,
   output logic [15:0]                rsp_altitude,
   output logic [31:0]                rsp_timestamp,
   output logic [7:0]                 rsp_flag_bitmap,
   output logic [tprx_pkg::CNT_W-1:0] rsp_packet_length
);

   logic [3:0]         team_id_ff;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   tprx_pkg::word_type push_word;
   tprx_pkg::word_type pop_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         team_id_ff <= '0;
      end else if (csr_wr_en) begin
         team_id_ff <= csr_wr_data;
      end
   end

   tprx_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_word        (push_word)
   );

   tprx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .empty     (q_empty)
   );

   tprx_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .team_id               (team_id_ff),
      .q_word                (pop_word),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_latitude          (rsp_latitude),
      .rsp_longitude         (rsp_longitude),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_altitude          (rsp_altitude),
      .rsp_timestamp         (rsp_timestamp),
      .rsp_flag_bitmap       (rsp_flag_bitmap),
      .rsp_packet_length     (rsp_packet_length)
   );

endmodule

// ===== hdl/tprx_checker.sv =====
module tprx_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [2:0]                 rsp_status,
   input logic signed [23:0]         rsp_latitude,
   input logic [15:0]                rsp_altitude,
   input logic [7:0]                 rsp_flag_bitmap,
   input logic [tprx_pkg::CNT_W-1:0] rsp_packet_length
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_packet_length))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packet_length != '0
         && rsp_packet_length <= tprx_pkg::MAX_LEN)
      else $error("packet length out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tprx_pkg::STATUS_TEL_OK |->
         rsp_packet_length >= tprx_pkg::MIN_TELEMETRY && rsp_flag_bitmap == '0)
      else $error("bad telemetry result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tprx_pkg::STATUS_SCI_OK |->
         rsp_packet_length >= tprx_pkg::MIN_SCIENTIFIC
         && rsp_latitude == '0 && rsp_altitude == '0)
      else $error("bad scientific result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tprx_pkg::STATUS_TEL_OK
         && rsp_status != tprx_pkg::STATUS_SCI_OK |->
         rsp_latitude == '0 && rsp_altitude == '0 && rsp_flag_bitmap == '0)
      else $error("failed packet carries fields");

endmodule

bind telemetry_packet_receiver_unit tprx_checker u_tprx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_latitude      (rsp_latitude),
   .rsp_altitude      (rsp_altitude),
   .rsp_flag_bitmap   (rsp_flag_bitmap),
   .rsp_packet_length (rsp_packet_length)
);

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD = 10;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 210;
   localparam int PHASE_PACKETS = 4;
   localparam int SEND_IDLE [4] = '{0, 57, 0, 30};
   localparam int RECV_STALL [4] = '{0, 0, 57, 30};

   typedef struct packed {
      logic [2:0]                 status;
      logic [23:0]                latitude;
      logic [23:0]                longitude;
      logic [15:0]                vertical_velocity;
      logic [15:0]                altitude;
      logic [31:0]                timestamp;
      logic [7:0]                 flag_bitmap;
      logic [tprx_pkg::CNT_W-1:0] packet_length;
   } packet_summary_type;

   class packet_scoreboard;
      logic [3:0]  team;
      int          count;
      logic [7:0]  crc_all;
      logic [7:0]  crc_head;
      logic [7:0]  crc_prev;
      logic [7:0]  tail;
      logic [7:0]  check_byte;
      logic [7:0]  head;
      logic [23:0] lat;
      logic [23:0] lon;
      logic [15:0] vvel;
      logic [15:0] alt;
      logic [31:0] stamp;
      logic [7:0]  bitmap;
      packet_summary_type awaited_verdicts[$];
      int errors;
      int bytes_seen;
      int results_seen;
      int status_seen[8];

      function new();
         team = 4'h0;
         errors = 0;
         bytes_seen = 0;
         results_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_packet();
      endfunction

      static function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
         logic [7:0] r;
         r = crc;
         for (int i = 7; i >= 0; i--) begin
            r = {r[6:0], 1'b0} ^ ((r[7] ^ b[i]) ? tprx_pkg::CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      function void clear_packet();
         count = 0;
         crc_all = 8'h00;
         crc_head = 8'h00;
         crc_prev = 8'h00;
         tail = 8'h00;
         check_byte = 8'h00;
         head = 8'h00;
         lat = '0;
         lon = '0;
         vvel = '0;
         alt = '0;
         stamp = '0;
         bitmap = '0;
      endfunction

      function void set_team(logic [3:0] v);
         team = v;
      endfunction

      function int outstanding();
         return awaited_verdicts.size();
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         packet_summary_type want;
         logic [3:0] kind;
         bit sci;
         bit tel;
         bytes_seen++;
         if (count < tprx_pkg::MAX_PACKET) begin
            sci = head[7:4] == tprx_pkg::KIND_SCIENTIFIC;
            if (count == 0) head = b;
            if (count >= 1 && count <= 3) lat = {lat[15:0], b};
            if (count >= 4 && count <= 6) lon = {lon[15:0], b};
            if (count == 7 || count == 8) vvel = {vvel[7:0], b};
            if (count == 9 || count == 10) alt = {alt[7:0], b};
            if (count == 5) bitmap = b;
            if (count == 15) check_byte = b;
            if (sci ? (count >= 1 && count <= 4) : (count >= 11 && count <= 14)) begin
               stamp = {stamp[23:0], b};
            end
            crc_prev = crc_all;
            crc_all = crc_next(crc_all, b);
            tail = b;
            count++;
            if (count == tprx_pkg::CRC_SPAN) crc_head = crc_all;
         end
         if (!fin) return;
         kind = head[7:4];
         tel = kind == tprx_pkg::KIND_TELEMETRY;
         sci = kind == tprx_pkg::KIND_SCIENTIFIC;
         want = '0;
         if (!tel && !sci) begin
            want.status = tprx_pkg::STATUS_BAD_TYPE;
         end else if (count < (tel ? tprx_pkg::MIN_TELEMETRY : tprx_pkg::MIN_SCIENTIFIC)) begin
            want.status = tprx_pkg::STATUS_TOO_SHORT;
         end else if (head[3:0] != team) begin
            want.status = tprx_pkg::STATUS_BAD_TEAM;
         end else if (tel ? (crc_head != check_byte) : (crc_prev != tail)) begin
            want.status = tprx_pkg::STATUS_BAD_CRC;
         end else if (tel) begin
            want.status = tprx_pkg::STATUS_TEL_OK;
            want.latitude = lat;
            want.longitude = lon;
            want.vertical_velocity = vvel;
            want.altitude = alt;
            want.timestamp = stamp;
         end else begin
            want.status = tprx_pkg::STATUS_SCI_OK;
            want.timestamp = stamp;
            want.flag_bitmap = bitmap;
         end
         want.packet_length = tprx_pkg::CNT_W'(count);
         awaited_verdicts.push_back(want);
         clear_packet();
      endfunction

      function void diff_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(packet_summary_type got);
         packet_summary_type want;
         results_seen++;
         status_seen[got.status]++;
         if (awaited_verdicts.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, got status %0d length %0d",
                     $time, got.status, got.packet_length);
            return;
         end
         want = awaited_verdicts.pop_front();
         diff_field("status", 32'(want.status), 32'(got.status));
         diff_field("latitude", 32'(want.latitude), 32'(got.latitude));
         diff_field("longitude", 32'(want.longitude), 32'(got.longitude));
         diff_field("vertical_velocity", 32'(want.vertical_velocity),
                    32'(got.vertical_velocity));
         diff_field("altitude", 32'(want.altitude), 32'(got.altitude));
         diff_field("timestamp", want.timestamp, got.timestamp);
         diff_field("flag_bitmap", 32'(want.flag_bitmap), 32'(got.flag_bitmap));
         diff_field("packet_length", 32'(want.packet_length), 32'(got.packet_length));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [3:0]                 csr_wr_data = 4'h0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       req_last_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [2:0]                 rsp_status;
   logic signed [23:0]         rsp_latitude;
   logic signed [23:0]         rsp_longitude;
   logic signed [15:0]         rsp_vertical_velocity;
   logic [15:0]                rsp_altitude;
   logic [31:0]                rsp_timestamp;
   logic [7:0]                 rsp_flag_bitmap;
   logic [tprx_pkg::CNT_W-1:0] rsp_packet_length;

   packet_scoreboard sb;
   logic [7:0] frame[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;

   telemetry_packet_receiver_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_latitude          (rsp_latitude),
      .rsp_longitude         (rsp_longitude),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_altitude          (rsp_altitude),
      .rsp_timestamp         (rsp_timestamp),
      .rsp_flag_bitmap       (rsp_flag_bitmap),
      .rsp_packet_length     (rsp_packet_length)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_status, rsp_latitude, rsp_longitude, rsp_vertical_velocity,
                             rsp_altitude, rsp_timestamp, rsp_flag_bitmap, rsp_packet_length});
         end
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte, req_last_byte);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.outstanding());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] frame_crc(int n);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < n; i++) c = packet_scoreboard::crc_next(c, frame[i]);
      return c;
   endfunction

   function automatic void build_frame(logic [3:0] team);
      int pick;
      int len;
      int kept;
      int span;
      int floor_len;
      logic [3:0] kind;
      logic [3:0] owner;
      logic [7:0] v;
      bit sci;
      frame.delete();
      pick = $urandom_range(99);
      sci = $urandom_range(2) == 0;
      owner = team;
      kind = sci ? tprx_pkg::KIND_SCIENTIFIC : tprx_pkg::KIND_TELEMETRY;
      floor_len = sci ? tprx_pkg::MIN_SCIENTIFIC : tprx_pkg::MIN_TELEMETRY;
      if (pick < 12) begin
         len = $urandom_range(1, 20);
      end else if (pick < 22) begin
         len = $urandom_range(1, floor_len - 1);
      end else if ($urandom_range(7) == 0) begin
         len = sci ? $urandom_range(tprx_pkg::MAX_PACKET - 2, tprx_pkg::MAX_PACKET + 8)
                   : $urandom_range(floor_len, tprx_pkg::MAX_PACKET + 8);
      end else begin
         len = floor_len + $urandom_range(0, 5);
      end
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = 8'h80;
            3: v = 8'h7F;
            default: v = 8'($urandom_range(255));
         endcase
         frame.push_back(v);
      end
      if (pick < 6) return;
      if (pick < 12) begin
         do kind = 4'($urandom_range(15));
         while (kind == tprx_pkg::KIND_TELEMETRY || kind == tprx_pkg::KIND_SCIENTIFIC);
         frame[0] = {kind, frame[0][3:0]};
         return;
      end
      if (pick >= 22 && pick < 32) owner = team + 4'($urandom_range(1, 15));
      frame[0] = {kind, owner};
      if (len >= floor_len) begin
         kept = (len < tprx_pkg::MAX_PACKET) ? len : tprx_pkg::MAX_PACKET;
         span = sci ? kept - 1 : tprx_pkg::CRC_SPAN;
         frame[span] = frame_crc(span);
         if (pick >= 32 && pick < 44) frame[span] ^= 8'($urandom_range(1, 255));
      end
   endfunction

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_rx_byte <= frame[i];
         req_last_byte <= (i == frame.size() - 1);
         @(posedge clock);
         // hold the word until the block takes it
         while (req_stall) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_team(logic [3:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_team(v);
   endtask

   initial begin
      int sent;
      int packets;
      logic [3:0] team_now;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_team(4'h0);

      frame = '{8'h00};
      send_frame();
      frame = '{8'hFF};
      send_frame();
      frame = '{8'h10};
      send_frame();
      frame = '{8'hA0};
      send_frame();
      frame = '{8'hA0, 8'h80, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'h80, 8'h00,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      frame.push_back(frame_crc(tprx_pkg::CRC_SPAN));
      send_frame();

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: team_now = 4'hF;
            2: team_now = 4'h0;
            default: team_now = 4'($urandom_range(1, 14));
         endcase
         write_team(team_now);
         idle_pct = SEND_IDLE[phase];
         stall_pct = RECV_STALL[phase];
         sent = 0;
         packets = 0;
         while (sent < PHASE_BYTES || packets < PHASE_PACKETS) begin
            build_frame(team_now);
            send_frame();
            sent += frame.size();
            packets++;
         end
      end
      settle();

      $display("%0d bytes in %0d packets: %0d telemetry and %0d scientific accepted,",
               sb.bytes_seen, sb.results_seen, sb.status_seen[tprx_pkg::STATUS_TEL_OK],
               sb.status_seen[tprx_pkg::STATUS_SCI_OK]);
      $display("rejects: type %0d, length %0d, team %0d, crc %0d over four pacing modes",
               sb.status_seen[tprx_pkg::STATUS_BAD_TYPE],
               sb.status_seen[tprx_pkg::STATUS_TOO_SHORT],
               sb.status_seen[tprx_pkg::STATUS_BAD_TEAM],
               sb.status_seen[tprx_pkg::STATUS_BAD_CRC]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
